/* rtl/eeasc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeasc_pkg: shared types and constants
// Types and constant tables shared by the electrical angle sine/cosine core.
// ----------------------------------------------------------------------------
package eeasc_pkg;

  // Width of the CORDIC x and y datapath, Q2.30 with headroom.
  localparam int XW = 34;
  // Width of the mechanical speed times pole pair product.
  localparam int SpdProdW = 39;
  // Largest number of rotation cells that the angle table supports.
  localparam int MaxStages = 24;

  // Starting x value: the inverse CORDIC gain in Q2.30.
  localparam logic signed [XW-1:0] CordicGainQ30 = 34'sd652032874;

  // Configuration register indexes.
  localparam logic [1:0] RegPolePairs   = 2'd0;
  localparam logic [1:0] RegAlignOffset = 2'd1;
  localparam logic [1:0] RegFrameCorr   = 2'd2;

  // atan(2^-i) as a fraction of one turn, scaled by 2^32.
  localparam logic [31:0] AtanTurns [MaxStages] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic [6:0]  pole_pair_count;
    logic [15:0] alignment_offset;
    logic [15:0] frame_correction;
  } cfg_t;

  // Data handed from one pipeline cell to the next.
  typedef struct packed {
    logic signed [XW-1:0]       x;
    logic signed [XW-1:0]       y;
    logic [31:0]                z;
    logic [15:0]                elec_angle;
    logic                       flip;
    logic signed [SpdProdW-1:0] spd_prod;
    logic                       spd_present;
  } cell_data_t;

endpackage

/* rtl/eeasc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeasc_in_if / eeasc_out_if: item channels
// Valid/ready channels for encoder readings and angle results.
// ----------------------------------------------------------------------------
interface eeasc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mech_angle;
  logic signed [31:0] mech_speed;
  logic               speed_present;

  modport source (output valid, mech_angle, mech_speed, speed_present, input ready);
  modport sink   (input valid, mech_angle, mech_speed, speed_present, output ready);
endinterface

interface eeasc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elec_angle;
  logic signed [15:0] sine_value;
  logic signed [15:0] cosine_value;
  logic signed [31:0] elec_speed;
  logic               speed_valid;

  modport source (output valid, elec_angle, sine_value, cosine_value, elec_speed,
                  speed_valid, input ready);
  modport sink   (input valid, elec_angle, sine_value, cosine_value, elec_speed,
                  speed_valid, output ready);
endinterface

/* rtl/eeasc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeasc_front: angle and speed preparation cell
// Forms the wrapped electrical angle, folds it into the CORDIC range and
// multiplies the mechanical speed by the pole pair count.
// ----------------------------------------------------------------------------
module eeasc_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  eeasc_pkg::cfg_t         cfg_i,
  eeasc_in_if.sink                in_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output eeasc_pkg::cell_data_t   data_o
);

  logic [ANGLE_BITS-1:0]                ang_prod;
  logic [ANGLE_BITS-1:0]                wrapped;
  logic [31:0]                          phase;
  logic                                 flip;
  logic signed [eeasc_pkg::SpdProdW-1:0] spd_prod;
  logic                                 valid_q;
  eeasc_pkg::cell_data_t                data_q;

  // Only the low ANGLE_BITS bits of the angle sum survive the wrap.
  assign ang_prod = ANGLE_BITS'(in_i.mech_angle[ANGLE_BITS-1:0] *
                                ANGLE_BITS'(cfg_i.pole_pair_count));
  assign wrapped  = ang_prod - ANGLE_BITS'(cfg_i.alignment_offset)
                  + ANGLE_BITS'(cfg_i.frame_correction);
  assign phase    = {wrapped, {(32 - ANGLE_BITS){1'b0}}};
  // Second and third quadrants are rotated by half a turn.
  assign flip     = phase[31] ^ phase[30];
  assign spd_prod = in_i.mech_speed * $signed({1'b0, cfg_i.pole_pair_count});

  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q.x           <= eeasc_pkg::CordicGainQ30;
      data_q.y           <= '0;
      data_q.z           <= {phase[31] ^ flip, phase[30:0]};
      data_q.elec_angle  <= phase[31:16];
      data_q.flip        <= flip;
      data_q.spd_prod    <= spd_prod;
      data_q.spd_present <= in_i.speed_present;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/eeasc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeasc_cell: one CORDIC rotation cell
// Rotates x and y by the fixed angle of its stage and registers the result.
// ----------------------------------------------------------------------------
module eeasc_cell #(
  parameter int STAGE = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  eeasc_pkg::cell_data_t data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output eeasc_pkg::cell_data_t data_o
);

  logic signed [eeasc_pkg::XW-1:0] dx;
  logic signed [eeasc_pkg::XW-1:0] dy;
  logic                            valid_q;
  eeasc_pkg::cell_data_t           data_q;
  eeasc_pkg::cell_data_t           data_d;

  assign dx = data_i.y >>> STAGE;
  assign dy = data_i.x >>> STAGE;

  always_comb begin
    data_d = data_i;
    if (!data_i.z[31]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - eeasc_pkg::AtanTurns[STAGE];
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + eeasc_pkg::AtanTurns[STAGE];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/eeasc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeasc_back: result cell
// Undoes the half-turn fold, rounds sine and cosine to Q1.15, saturates the
// electrical speed and holds the result for the output channel.
// ----------------------------------------------------------------------------
module eeasc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  eeasc_pkg::cell_data_t data_i,
  eeasc_out_if.source           out_o
);

  localparam int EW = eeasc_pkg::XW + 1;

  logic signed [EW-1:0] x_ext;
  logic signed [EW-1:0] y_ext;
  logic signed [EW-1:0] x_rnd;
  logic signed [EW-1:0] y_rnd;
  logic signed [15:0]   cos_d;
  logic signed [15:0]   sin_d;
  logic signed [31:0]   spd_d;
  logic                 valid_q;
  logic signed [15:0]   angle_q;
  logic signed [15:0]   sin_q;
  logic signed [15:0]   cos_q;
  logic signed [31:0]   spd_q;
  logic                 spd_vld_q;

  assign x_ext = data_i.flip ? -EW'(data_i.x) : EW'(data_i.x);
  assign y_ext = data_i.flip ? -EW'(data_i.y) : EW'(data_i.y);
  // Round half up from Q2.30 to Q1.15.
  assign x_rnd = (x_ext + EW'(16384)) >>> 15;
  assign y_rnd = (y_ext + EW'(16384)) >>> 15;

  always_comb begin
    if (x_rnd > EW'(32767)) begin
      cos_d = 16'sd32767;
    end else if (x_rnd < -EW'(32768)) begin
      cos_d = -16'sd32768;
    end else begin
      cos_d = x_rnd[15:0];
    end
    if (y_rnd > EW'(32767)) begin
      sin_d = 16'sd32767;
    end else if (y_rnd < -EW'(32768)) begin
      sin_d = -16'sd32768;
    end else begin
      sin_d = y_rnd[15:0];
    end
    if (!data_i.spd_present) begin
      spd_d = '0;
    end else if (data_i.spd_prod > eeasc_pkg::SpdProdW'(2147483647)) begin
      spd_d = 32'sh7FFFFFFF;
    end else if (data_i.spd_prod < -eeasc_pkg::SpdProdW'(64'sd2147483648)) begin
      spd_d = 32'sh80000000;
    end else begin
      spd_d = data_i.spd_prod[31:0];
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      angle_q   <= data_i.elec_angle;
      sin_q     <= sin_d;
      cos_q     <= cos_d;
      spd_q     <= spd_d;
      spd_vld_q <= data_i.spd_present;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.elec_angle   = angle_q;
  assign out_o.sine_value   = sin_q;
  assign out_o.cosine_value = cos_q;
  assign out_o.elec_speed   = spd_q;
  assign out_o.speed_valid  = spd_vld_q;

endmodule

/* rtl/encoder_electrical_angle_sincos_core.sv */
`timescale 1ns / 1ps
// An item is registered in the front cell, each rotation cell and then the back cell.
// Throughput: one transfer per cycle without output stalls; every rotation cell holds its own item.
// The rate is set by the chain of registered cells, each of which passes an item on per cycle.
// Reset empties every cell and loads pole_pair_count = 1, offset and correction = 0.
// ----------------------------------------------------------------------------
// encoder_electrical_angle_sincos_core: electrical angle, sine and cosine
// Turns a multi-turn encoder angle into a wrapped electrical angle with its
// sine and cosine, and scales the mechanical speed by the pole pair count.
// ----------------------------------------------------------------------------
module encoder_electrical_angle_sincos_core #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  eeasc_in_if.sink    in_i,
  eeasc_out_if.source out_o
);

  // The angle table holds at most MaxStages entries; extra stages are dropped.
  localparam int NumStages = (CORDIC_STAGES > eeasc_pkg::MaxStages) ?
                             eeasc_pkg::MaxStages : CORDIC_STAGES;

  eeasc_pkg::cfg_t       cfg_q;
  eeasc_pkg::cell_data_t chain_data [NumStages+1];
  logic                  chain_vld  [NumStages+1];
  logic                  chain_rdy  [NumStages+1];

  // Configuration registers. The user must make writes arrive only while the
  // pipeline is empty, so that a register never changes under an item in flight;
  // the block itself does not enforce this. Writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pole_pair_count  <= 7'd1;
      cfg_q.alignment_offset <= '0;
      cfg_q.frame_correction <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eeasc_pkg::RegPolePairs:   cfg_q.pole_pair_count  <= cfg_wdata_i[6:0];
        eeasc_pkg::RegAlignOffset: cfg_q.alignment_offset <= cfg_wdata_i;
        eeasc_pkg::RegFrameCorr:   cfg_q.frame_correction <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The front cell wraps the angle to one electrical turn, folds the second
  // and third quadrants by half a turn and starts the speed product.
  eeasc_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .valid_o (chain_vld[0]),
    .ready_i (chain_rdy[0]),
    .data_o  (chain_data[0])
  );

  // The rotation chain: each cell applies one micro-rotation and hands its
  // item to the next cell. A cell takes a new item whenever it is empty or
  // its neighbor takes its current one, so bubbles close up under a stall.
  for (genvar k = 0; k < NumStages; k++) begin : g_cell
    eeasc_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[k]),
      .ready_o (chain_rdy[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_vld[k+1]),
      .ready_i (chain_rdy[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // The back cell undoes the fold, rounds to Q1.15 and holds the result
  // until the output transfer completes.
  eeasc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_vld[NumStages]),
    .ready_o (chain_rdy[NumStages]),
    .data_i  (chain_data[NumStages]),
    .out_o   (out_o)
  );

endmodule

/* verif/encoder_electrical_angle_sincos_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_electrical_angle_sincos_core_test: self-checking bench for the core
// Streams encoder readings through the core under several pole pair, offset
// and correction settings, predicts every result with an independent CORDIC
// model of the same fixed-point arithmetic and compares field by field. Both
// channels idle and stall at random, with one long output hold-off and one
// full drain of the pipeline in the middle of a setting.
// ----------------------------------------------------------------------------
module encoder_electrical_angle_sincos_core_test;

  // The core is built with its default angle resolution and stage count, and the
  // predictor below assumes the same.
  localparam int AngleW = 16;
  localparam int RotStages = 16;
  localparam int PipeLatency = RotStages + 2;

  // Starting x of the rotation, the inverse CORDIC gain in Q2.30.
  localparam longint InvGainQ30 = 64'sd652032874;

  // Rotation angle of each stage, atan(2^-i) as a fraction of one turn times 2^32.
  localparam logic [31:0] StepTurns [RotStages] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  // Directed angles: quadrant and octant points, one count either side of the
  // quadrant boundaries, the full-scale ends of the multi-turn range.
  localparam logic [31:0] AngleCorners [20] = '{
    32'h00000000, 32'h00004000, 32'h00008000, 32'h0000C000,
    32'h00002000, 32'h00006000, 32'h0000A000, 32'h0000E000,
    32'h00003FFF, 32'h00004001, 32'h0000BFFF, 32'h0000C001,
    32'h0000FFFF, 32'h00000001, 32'h7FFFFFFF, 32'h80000000,
    32'h00007FFF, 32'h00008001, 32'hFFFFFFFF, 32'h12345678
  };
  localparam logic [31:0] SpeedCorners [4] = '{
    32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00000000
  };

  // Register settings applied one per phase after the reset phase: the top and
  // bottom of every field, a zero pole pair count, the largest raw 7-bit count,
  // and a write with junk above the 7-bit pole pair field.
  localparam int PresetCount = 6;
  localparam logic [15:0] PresetPoles  [PresetCount] = '{
    16'd64, 16'd0, 16'd127, 16'd7, 16'hFF83, 16'd1
  };
  localparam logic [15:0] PresetAlign  [PresetCount] = '{
    16'hFFFF, 16'h8000, 16'h0001, 16'h1234, 16'h0000, 16'h4000
  };
  localparam logic [15:0] PresetFrame  [PresetCount] = '{
    16'hFFFF, 16'h0001, 16'h0000, 16'hABCD, 16'h8000, 16'hC000
  };

  localparam int PhaseCount = 10;
  localparam int ItemsPerPhase = 175;
  localparam int HoldOffCycles = 300;

  typedef struct packed {
    logic signed [31:0] mech_angle;
    logic signed [31:0] mech_speed;
    logic               speed_present;
  } reading_t;

  typedef struct packed {
    logic signed [15:0] elec_angle;
    logic signed [15:0] sine_value;
    logic signed [15:0] cosine_value;
    logic signed [31:0] elec_speed;
    logic               speed_valid;
  } angle_result_t;

  logic        clk_i;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  eeasc_in_if  reading_if ();
  eeasc_out_if result_if ();

  encoder_electrical_angle_sincos_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (reading_if),
    .out_o       (result_if)
  );

  // Register values as the predictor sees them. They only change while the
  // pipeline is empty, so a prediction made at an input transfer always uses the
  // setting that the core applies to that reading.
  logic [6:0]  poles_now;
  logic [15:0] align_now;
  logic [15:0] frame_now;

  reading_t      readings_pending [$];
  angle_result_t results_expected [$];

  int  mismatch_count;
  bit  reading_taken;
  int  burst_left;
  int  gap_left;
  int  hold_off_asks;
  int  hold_off_seen;
  int  hold_off_left;
  int  stall_mode;
  int  stall_span;
  int  stall_tick;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Round a Q2.30 value to nearest, half up, into Q1.15 and clamp to 16 bits.
  function automatic logic [15:0] round_to_q15(longint value);
    longint rounded;
    rounded = (value + 64'sd16384) >>> 15;
    if (rounded > 64'sd32767) rounded = 64'sd32767;
    else if (rounded < -64'sd32768) rounded = -64'sd32768;
    return rounded[15:0];
  endfunction

  // Electrical angle, its sine and cosine, and the scaled speed for one reading.
  function automatic angle_result_t electrical_angle_of(reading_t rd);
    logic [31:0]   turn_sum;
    logic [15:0]   wrapped;
    logic [31:0]   residual;
    logic          half_turn;
    longint        x;
    longint        y;
    longint        dx;
    longint        dy;
    longint        speed_prod;
    int            i;
    angle_result_t res;
    // Multi-turn angle times pole pairs; only the low bits of one turn survive,
    // so the 32-bit wrap of the product is harmless.
    turn_sum = $unsigned(rd.mech_angle) * {25'd0, poles_now}
               - {16'd0, align_now} + {16'd0, frame_now};
    wrapped  = turn_sum[AngleW-1:0];
    residual = {wrapped, 16'd0};
    // The rotation only converges within a quarter turn either side of zero, so
    // the second and third quadrants are turned by half a turn first and the
    // result is negated afterwards.
    half_turn = residual[31] ^ residual[30];
    if (half_turn) residual = residual + 32'h80000000;
    x = InvGainQ30;
    y = 0;
    for (i = 0; i < RotStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!residual[31]) begin
        x = x - dx;
        y = y + dy;
        residual = residual - StepTurns[i];
      end else begin
        x = x + dx;
        y = y - dy;
        residual = residual + StepTurns[i];
      end
    end
    if (half_turn) begin
      x = -x;
      y = -y;
    end
    res.elec_angle   = wrapped;
    res.sine_value   = round_to_q15(y);
    res.cosine_value = round_to_q15(x);
    if (rd.speed_present) begin
      speed_prod = longint'(rd.mech_speed) * longint'(poles_now);
      if (speed_prod > 64'sd2147483647) speed_prod = 64'sd2147483647;
      else if (speed_prod < -64'sd2147483648) speed_prod = -64'sd2147483648;
      res.elec_speed  = speed_prod[31:0];
      res.speed_valid = 1'b1;
    end else begin
      res.elec_speed  = '0;
      res.speed_valid = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [31:0] random_angle();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $urandom_range(0, 4000) - 2000;
      // Close to a mechanical quadrant boundary.
      default: return ($urandom << 14) + $urandom_range(0, 4) - 2;
    endcase
  endfunction

  function automatic logic [31:0] random_speed();
    logic [31:0] limit_mag;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 4000) - 2000;
      3: begin
        // Right at the point where the scaled speed starts to saturate.
        limit_mag = (poles_now == 7'd0) ? 32'h7FFFFFFF : 32'h7FFFFFFF / poles_now;
        limit_mag = limit_mag + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? limit_mag : ~limit_mag;
      end
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic void queue_reading(logic [31:0] angle, logic [31:0] speed,
                                        logic present);
    reading_t rd;
    rd.mech_angle    = angle;
    rd.mech_speed    = speed;
    rd.speed_present = present;
    readings_pending.push_back(rd);
  endfunction

  function automatic void queue_random_readings(int count);
    int k;
    for (k = 0; k < count; k++)
      queue_reading(random_angle(), random_speed(), $urandom_range(0, 3) != 0);
  endfunction

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // A register write takes effect at the rising edge inside the one-cycle pulse.
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      eeasc_pkg::RegPolePairs:   poles_now = value[6:0];
      eeasc_pkg::RegAlignOffset: align_now = value;
      eeasc_pkg::RegFrameCorr:   frame_now = value;
      default: ;
    endcase
  endtask

  // Every reading has gone in and every result has come out. Each reading
  // makes exactly one result, so the pipeline is empty at this point.
  task automatic wait_drained();
    while (readings_pending.size() != 0 || reading_if.valid ||
           results_expected.size() != 0)
      @(posedge clk_i);
  endtask

  // Input monitor and output checker. Both sample at the rising edge, where the
  // values seen are those held since the previous falling edge.
  always @(posedge clk_i) begin
    reading_t      accepted;
    angle_result_t want;
    reading_taken = 1'b0;
    if (rst_n) begin
      if (reading_if.valid && reading_if.ready) begin
        accepted.mech_angle    = reading_if.mech_angle;
        accepted.mech_speed    = reading_if.mech_speed;
        accepted.speed_present = reading_if.speed_present;
        results_expected.push_back(electrical_angle_of(accepted));
        reading_taken = 1'b1;
      end
      if (result_if.valid && result_if.ready) begin
        if (results_expected.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = results_expected.pop_front();
          check_field("elec_angle", {16'd0, result_if.elec_angle}, {16'd0, want.elec_angle});
          check_field("sine_value", {16'd0, result_if.sine_value}, {16'd0, want.sine_value});
          check_field("cosine_value", {16'd0, result_if.cosine_value},
                      {16'd0, want.cosine_value});
          check_field("elec_speed", result_if.elec_speed, want.elec_speed);
          check_field("speed_valid", {31'd0, result_if.speed_valid},
                      {31'd0, want.speed_valid});
        end
      end
    end
  end

  // Reading driver. A reading stays on the channel until its transfer; after
  // that the next one follows at once within a burst, or after a random gap.
  // A gap of zero between bursts gives long stretches with no idling at all.
  always @(negedge clk_i) begin
    reading_t queued;
    if (rst_n && (!reading_if.valid || reading_taken)) begin
      if (gap_left > 0 || readings_pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        reading_if.valid <= 1'b0;
      end else begin
        queued = readings_pending.pop_front();
        reading_if.valid         <= 1'b1;
        reading_if.mech_angle    <= queued.mech_angle;
        reading_if.mech_speed    <= queued.mech_speed;
        reading_if.speed_present <= queued.speed_present;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Result receiver. It switches between stall patterns every so often: always
  // ready, coin-flip ready, a fixed one-in-four stall and mostly stalled. On
  // request it holds off for a long stretch so that the pipeline fills up and
  // the core has to refuse readings.
  always @(negedge clk_i) begin
    if (hold_off_asks != hold_off_seen) begin
      hold_off_seen = hold_off_asks;
      hold_off_left = HoldOffCycles;
    end
    if (!rst_n || hold_off_left > 0) begin
      if (hold_off_left > 0) hold_off_left--;
      result_if.ready <= 1'b0;
    end else begin
      if (stall_span > 0) begin
        stall_span--;
      end else begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(16, 200);
      end
      stall_tick++;
      case (stall_mode)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= 1'($urandom_range(0, 1));
        2: result_if.ready <= (stall_tick % 4) != 0;
        default: result_if.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Main sequence: reset, a directed set and random readings at the reset values of
  // the registers, then one phase of random readings per register setting.
  initial begin
    int phase;
    int k;
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_idx                  = eeasc_pkg::RegPolePairs;
    cfg_wdata                = '0;
    reading_if.valid         = 1'b0;
    reading_if.mech_angle    = '0;
    reading_if.mech_speed    = '0;
    reading_if.speed_present = 1'b0;
    result_if.ready          = 1'b0;
    poles_now                = 7'd1;
    align_now                = '0;
    frame_now                = '0;
    mismatch_count           = 0;
    burst_left               = 0;
    gap_left                 = 0;
    hold_off_asks            = 0;
    hold_off_seen            = 0;
    hold_off_left            = 0;
    stall_mode               = 0;
    stall_span               = 0;
    stall_tick               = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase == 0) begin
        // With the reset setting the electrical angle equals the mechanical
        // one, so the corner angles keep their place around the quadrant boundaries. The
        // speed corners rotate through them, and every fifth reading carries a
        // speed that is marked as not present.
        for (k = 0; k < 20; k++)
          queue_reading(AngleCorners[k], SpeedCorners[k % 4] ^ (k % 5 == 4 ? 32'h5A : 0),
                        k % 5 != 4);
        queue_random_readings(ItemsPerPhase - 25);
      end else begin
        wait_drained();
        if (phase <= PresetCount) begin
          write_register(eeasc_pkg::RegPolePairs, PresetPoles[phase-1]);
          write_register(eeasc_pkg::RegAlignOffset, PresetAlign[phase-1]);
          write_register(eeasc_pkg::RegFrameCorr, PresetFrame[phase-1]);
        end else begin
          write_register(eeasc_pkg::RegPolePairs, 16'($urandom_range(1, 64)));
          write_register(eeasc_pkg::RegAlignOffset, 16'($urandom));
          write_register(eeasc_pkg::RegFrameCorr, 16'($urandom));
        end
        if (phase == 4) begin
          // The sender stops halfway and waits for the pipeline to empty
          // completely before it resumes.
          queue_random_readings(ItemsPerPhase / 2);
          wait_drained();
          queue_random_readings(ItemsPerPhase - ItemsPerPhase / 2);
        end else begin
          queue_random_readings(ItemsPerPhase);
        end
        if (phase == 2) begin
          @(posedge clk_i);
          hold_off_asks++;
        end
      end
    end

    wait_drained();
    // Give a stray extra result the time to show up.
    repeat (PipeLatency + 8) @(posedge clk_i);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // The timeout lies far beyond the slowest correct run.
  initial begin
    #400000;
    $display("Timeout: %0d readings pending, %0d results outstanding",
             readings_pending.size(), results_expected.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* encoder_electrical_angle_sincos_core.f */
rtl/eeasc_pkg.sv
rtl/eeasc_if.sv
rtl/eeasc_front.sv
rtl/eeasc_cell.sv
rtl/eeasc_back.sv
rtl/encoder_electrical_angle_sincos_core.sv
verif/encoder_electrical_angle_sincos_core_test.sv
